FILE: hdl/gcwds_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the windowed GC content and mean depth block.
package gcwds_pkg;

	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	localparam logic REG_WINDOW_WIDTH = 1'b0;
	localparam logic REG_MIN_VALID    = 1'b1;

	localparam logic [15:0] WINDOW_WIDTH_RESET = 16'd1000;
	localparam logic [15:0] MIN_VALID_RESET    = 16'd30;

	localparam logic [7:0] ASCII_G_UPPER = 8'h47;
	localparam logic [7:0] ASCII_C_UPPER = 8'h43;
	localparam logic [7:0] ASCII_N_UPPER = 8'h4E;
	localparam logic [7:0] ASCII_G_LOWER = 8'h67;
	localparam logic [7:0] ASCII_C_LOWER = 8'h63;
	localparam logic [7:0] ASCII_N_LOWER = 8'h6E;

	localparam int unsigned DVD_W       = 40;
	localparam int unsigned STEP_CNT_W  = 6;
	localparam logic [DVD_W-1:0] GC_SCALE = DVD_W'(25600);

	typedef struct packed {
		logic [7:0]  base;
		logic [15:0] depth;
		logic        sequence_start;
	} base_item_t;

	typedef struct packed {
		logic [14:0] gc_percent_fx;
		logic [6:0]  gc_bin;
		logic        all_unknown;
		logic        window_kept;
		logic [23:0] mean_depth_fx;
		logic [15:0] unknown_count;
	} win_stats_t;

endpackage

FILE: hdl/gc_window_depth_stats.sv
`timescale 1ns / 1ps
// Top level: windowed GC content and mean depth with one shared restoring divider.
//
// Bases arrive one per transaction. A base that closes a window holds off the
// next base until its result is done: a load step, the GC percent on the
// shared one-bit-per-cycle divider, then the mean depth on the same divider,
// and a move of the result into the output register (held while that
// register is still full).
// Bases that do not close a window are taken while a result waits downstream.
// A sequence start drops the partial window; a window_width of 0 acts as 1.
module gc_window_depth_stats (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [gcwds_pkg::PADDR_W-1:0]    paddr,
	input  logic [gcwds_pkg::PDATA_W-1:0]    pwdata,
	output logic [gcwds_pkg::PDATA_W-1:0]    prdata,
	output logic                             pready,
	input  logic                             base_valid,
	output logic                             base_ready,
	input  gcwds_pkg::base_item_t            base_item,
	output logic                             win_valid,
	input  logic                             win_ready,
	output gcwds_pkg::win_stats_t            win_stats
);
	import gcwds_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LOAD = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;
	localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(DVD_W - 1);

	logic [15:0] window_width_q;
	logic [15:0] min_valid_q;

	logic [15:0] pos_q;
	logic [15:0] gc_q;
	logic [15:0] unk_q;
	logic [31:0] dsum_q;

	logic [1:0]  state_q;
	logic        op_q;
	logic [STEP_CNT_W-1:0] cnt_q;

	logic [15:0] valid_cnt_q;
	logic [15:0] win_gc_q;
	logic [15:0] win_unk_q;
	logic [31:0] win_dsum_q;
	logic        win_kept_q;
	logic        win_allu_q;
	logic [14:0] gc_res_q;

	logic [DVD_W-1:0] dvd_q;
	logic [15:0]      rem_q;

	logic        out_valid_q;
	win_stats_t  out_q;

	logic        cfg_wr;
	logic        accept;
	logic [15:0] width_eff;
	logic [15:0] pos_base, gc_base, unk_base;
	logic [31:0] dsum_base;
	logic        is_n, is_gc;
	logic [15:0] pos_n, gc_n, unk_n;
	logic [31:0] dsum_n;
	logic        closing;
	logic [15:0] valid_n;
	logic [17:0] unk_x4, bases_x3;
	logic [16:0] rem_sh;
	logic        rem_ge;
	logic [15:0] rem_next;
	logic [DVD_W-1:0] dvd_next;
	logic        out_free;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_comb begin
		unique case (paddr[2])
			REG_WINDOW_WIDTH: prdata = {16'd0, window_width_q};
			REG_MIN_VALID:    prdata = {16'd0, min_valid_q};
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_width_q <= WINDOW_WIDTH_RESET;
			min_valid_q    <= MIN_VALID_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_WINDOW_WIDTH: window_width_q <= pwdata[15:0];
				REG_MIN_VALID:    min_valid_q    <= pwdata[15:0];
				default:          ;
			endcase
		end
	end

	assign base_ready = (state_q == S_IDLE);
	assign accept     = base_valid & base_ready;
	assign out_free   = ~out_valid_q | win_ready;

	always_comb begin
		width_eff = (window_width_q == 16'd0) ? 16'd1 : window_width_q;
		pos_base  = base_item.sequence_start ? 16'd0 : pos_q;
		gc_base   = base_item.sequence_start ? 16'd0 : gc_q;
		unk_base  = base_item.sequence_start ? 16'd0 : unk_q;
		dsum_base = base_item.sequence_start ? 32'd0 : dsum_q;
		is_n  = (base_item.base == ASCII_N_UPPER) || (base_item.base == ASCII_N_LOWER);
		is_gc = (base_item.base == ASCII_G_UPPER) || (base_item.base == ASCII_C_UPPER) ||
			(base_item.base == ASCII_G_LOWER) || (base_item.base == ASCII_C_LOWER);
		pos_n  = pos_base + 16'd1;
		unk_n  = is_n ? unk_base + 16'd1 : unk_base;
		gc_n   = (!is_n && is_gc) ? gc_base + 16'd1 : gc_base;
		dsum_n = is_n ? dsum_base : dsum_base + {16'd0, base_item.depth};
		closing  = (pos_n >= width_eff);
		valid_n  = pos_n - unk_n;
		unk_x4   = {unk_n, 2'b00};
		bases_x3 = {2'b00, pos_n} + {1'b0, pos_n, 1'b0};
	end

	always_comb begin
		rem_sh   = {rem_q, dvd_q[DVD_W-1]};
		rem_ge   = (rem_sh >= {1'b0, valid_cnt_q});
		rem_next = rem_ge ? 16'(rem_sh - {1'b0, valid_cnt_q}) : rem_sh[15:0];
		dvd_next = {dvd_q[DVD_W-2:0], rem_ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			gc_q    <= '0;
			unk_q   <= '0;
			dsum_q  <= '0;
			state_q <= S_IDLE;
			op_q    <= 1'b0;
			cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (state_q == S_DONE && out_free) || (out_valid_q && !win_ready);
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (closing) begin
							pos_q   <= '0;
							gc_q    <= '0;
							unk_q   <= '0;
							dsum_q  <= '0;
							state_q <= S_LOAD;
						end else begin
							pos_q  <= pos_n;
							gc_q   <= gc_n;
							unk_q  <= unk_n;
							dsum_q <= dsum_n;
						end
					end
				end
				S_LOAD: begin
					op_q    <= 1'b0;
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == LAST_STEP) begin
						cnt_q <= '0;
						if (!op_q)
							op_q <= 1'b1;
						else
							state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q + STEP_CNT_W'(1);
					end
				end
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && closing) begin
			valid_cnt_q <= valid_n;
			win_gc_q    <= gc_n;
			win_unk_q   <= unk_n;
			win_dsum_q  <= dsum_n;
			win_kept_q  <= (unk_x4 < bases_x3) && (valid_n > min_valid_q);
			win_allu_q  <= (valid_n == 16'd0);
		end
		if (state_q == S_LOAD) begin
			dvd_q <= {24'd0, win_gc_q} * GC_SCALE;
			rem_q <= '0;
		end else if (state_q == S_DIV) begin
			if (cnt_q == LAST_STEP && !op_q) begin
				gc_res_q <= dvd_next[14:0];
				dvd_q    <= {win_dsum_q, 8'd0};
				rem_q    <= '0;
			end else begin
				dvd_q <= dvd_next;
				rem_q <= rem_next;
			end
		end
		if (state_q == S_DONE && out_free) begin
			out_q.gc_percent_fx <= win_allu_q ? 15'd0 : gc_res_q;
			out_q.gc_bin        <= win_allu_q ? 7'd0 : gc_res_q[14:8];
			out_q.all_unknown   <= win_allu_q;
			out_q.window_kept   <= win_kept_q;
			out_q.mean_depth_fx <= win_allu_q ? 24'd0 : dvd_q[23:0];
			out_q.unknown_count <= win_unk_q;
		end
	end

	assign win_valid = out_valid_q;
	assign win_stats = out_q;

endmodule

FILE: verif/gc_window_depth_stats_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the windowed GC content and mean depth block.
module gc_window_depth_stats_test;
	import gcwds_pkg::*;

	localparam logic [7:0] BASE_A_UPPER = 8'h41;
	localparam logic [7:0] BASE_T_UPPER = 8'h54;
	localparam logic [7:0] BASE_A_LOWER = 8'h61;
	localparam logic [7:0] BASE_T_LOWER = 8'h74;
	localparam logic [15:0] DEPTH_MAX = 16'd65534;
	localparam int SETTLE_CYCLES = 120;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_CHOKE} rx_mode_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;
	logic base_valid = 1'b0;
	logic base_ready;
	base_item_t base_item = '0;
	logic win_valid;
	logic win_ready = 1'b0;
	win_stats_t win_stats;

	base_item_t base_backlog[$];
	win_stats_t win_stats_due[$];

	logic [15:0] cfg_width;
	logic [15:0] cfg_min_valid;
	logic [15:0] win_pos;
	logic [15:0] gc_seen;
	logic [15:0] n_seen;
	logic [31:0] depth_total;

	bit base_taken;
	win_stats_t predicted;
	win_stats_t expected;
	int burst_left;
	int gap_left;
	int rx_tick;
	rx_mode_e rx_mode = RX_OPEN;
	int errors;
	int windows_checked;
	int all_n_windows;
	int kept_windows;
	int bases_queued;
	int settings_used;

	gc_window_depth_stats dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.base_valid(base_valid),
		.base_ready(base_ready),
		.base_item(base_item),
		.win_valid(win_valid),
		.win_ready(win_ready),
		.win_stats(win_stats)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic void clear_window();
		win_pos = '0;
		gc_seen = '0;
		n_seen = '0;
		depth_total = '0;
	endfunction

	// Fold one base into the open window; return 1 with its stats when it closes.
	function automatic bit tally_base(input base_item_t it, output win_stats_t res);
		logic [15:0] span;
		logic [15:0] valid;
		logic [63:0] gc_fx;
		logic [63:0] mean_fx;
		span = (cfg_width == 16'd0) ? 16'd1 : cfg_width;
		res = '0;
		if (it.sequence_start)
			clear_window();
		if (it.base == ASCII_N_UPPER || it.base == ASCII_N_LOWER) begin
			n_seen = n_seen + 16'd1;
		end else begin
			depth_total = depth_total + 32'(it.depth);
			if (it.base == ASCII_G_UPPER || it.base == ASCII_C_UPPER ||
			    it.base == ASCII_G_LOWER || it.base == ASCII_C_LOWER)
				gc_seen = gc_seen + 16'd1;
		end
		win_pos = win_pos + 16'd1;
		if (win_pos < span)
			return 1'b0;
		valid = win_pos - n_seen;
		gc_fx = '0;
		mean_fx = '0;
		if (valid != 16'd0) begin
			gc_fx = (64'(gc_seen) * 64'd25600) / 64'(valid);
			mean_fx = (64'(depth_total) * 64'd256) / 64'(valid);
		end
		res.gc_percent_fx = gc_fx[14:0];
		res.gc_bin = gc_fx[14:8];
		res.all_unknown = (valid == 16'd0);
		res.window_kept = (64'(n_seen) * 4 < 64'(win_pos) * 3) && (valid > cfg_min_valid);
		res.mean_depth_fx = mean_fx[23:0];
		res.unknown_count = n_seen;
		clear_window();
		return 1'b1;
	endfunction

	function automatic logic [7:0] pick_base(input int n_pct);
		int r;
		r = $urandom_range(99);
		if (r < n_pct)
			return $urandom_range(1) ? ASCII_N_UPPER : ASCII_N_LOWER;
		r = $urandom_range(99);
		if (r < 35) begin
			case ($urandom_range(3))
				0: return ASCII_G_UPPER;
				1: return ASCII_C_UPPER;
				2: return ASCII_G_LOWER;
				default: return ASCII_C_LOWER;
			endcase
		end
		if (r < 55)
			return 8'($urandom_range(255));
		case ($urandom_range(3))
			0: return BASE_A_UPPER;
			1: return BASE_T_UPPER;
			2: return BASE_A_LOWER;
			default: return BASE_T_LOWER;
		endcase
	endfunction

	function automatic logic [15:0] pick_depth(input int top_pct);
		int r;
		r = $urandom_range(99);
		if (r < top_pct)
			return DEPTH_MAX;
		if (r < top_pct + 10)
			return 16'd0;
		return 16'($urandom_range(65534));
	endfunction

	task automatic push_base(input logic [7:0] b, input logic [15:0] d, input logic s);
		base_item_t it;
		it.base = b;
		it.depth = d;
		it.sequence_start = s;
		base_backlog = {base_backlog, it};
		bases_queued++;
	endtask

	task automatic queue_bases(input int count, input int n_pct, input int start_pct,
			input int top_pct);
		for (int i = 0; i < count; i++)
			push_base(pick_base(n_pct), pick_depth(top_pct), $urandom_range(99) < start_pct);
	endtask

	// Wait until every base is taken and every window has come out, then let the block go idle.
	task automatic settle();
		while (base_backlog.size() != 0 || base_valid || win_stats_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_cycle(input logic idx, input logic wr, input logic [15:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= PDATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (!wr && prdata[15:0] !== value) begin
			errors++;
			$display("%0t: register %0d read back expected %0d actual %0d",
				$time, idx, value, prdata[15:0]);
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_reg(input logic idx, input logic [15:0] value);
		apb_cycle(idx, 1'b1, value);
		if (idx == REG_WINDOW_WIDTH)
			cfg_width = value;
		else
			cfg_min_valid = value;
		apb_cycle(idx, 1'b0, value);
	endtask

	task automatic configure(input logic [15:0] width, input logic [15:0] min_valid);
		set_reg(REG_WINDOW_WIDTH, width);
		set_reg(REG_MIN_VALID, min_valid);
		settings_used++;
	endtask

	task automatic check_field(input string field, input longint unsigned exp_v,
			input longint unsigned act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t: %s expected %0d actual %0d", $time, field, exp_v, act_v);
		end
	endtask

	// Sender: bursts of random length separated by random gaps.
	always @(negedge clk) begin
		if (!arst_n) begin
			base_valid <= 1'b0;
		end else if (base_valid && !base_taken) begin
		end else if (gap_left > 0) begin
			base_valid <= 1'b0;
			gap_left--;
		end else if (base_backlog.size() != 0) begin
			base_item <= base_backlog.pop_front();
			base_valid <= 1'b1;
			if (burst_left <= 1) begin
				burst_left = $urandom_range(1, 40);
				gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
			end else begin
				burst_left--;
			end
		end else begin
			base_valid <= 1'b0;
		end
	end

	// Receiver: ready follows a stall pattern redrawn at random among open, coin-flip and choke modes.
	always @(negedge clk) begin
		if (!arst_n) begin
			win_ready <= 1'b0;
		end else begin
			rx_tick++;
			if (rx_tick % 128 == 0)
				rx_mode = rx_mode_e'($urandom_range(2));
			case (rx_mode)
				RX_OPEN: win_ready <= 1'b1;
				RX_COIN: win_ready <= 1'($urandom_range(1));
				default: win_ready <= (rx_tick % 16) >= 12;
			endcase
		end
	end

	always @(posedge clk) begin
		base_taken = arst_n && base_valid && base_ready;
		if (base_taken && tally_base(base_item, predicted))
			win_stats_due = {win_stats_due, predicted};
		if (arst_n && win_valid && win_ready) begin
			if (win_stats_due.size() == 0) begin
				errors++;
				$display("%0t: window stats with none expected, actual %h", $time, win_stats);
			end else begin
				expected = win_stats_due.pop_front();
				check_field("gc_percent_fx", expected.gc_percent_fx, win_stats.gc_percent_fx);
				check_field("gc_bin", expected.gc_bin, win_stats.gc_bin);
				check_field("all_unknown", expected.all_unknown, win_stats.all_unknown);
				check_field("window_kept", expected.window_kept, win_stats.window_kept);
				check_field("mean_depth_fx", expected.mean_depth_fx, win_stats.mean_depth_fx);
				check_field("unknown_count", expected.unknown_count, win_stats.unknown_count);
				windows_checked++;
				all_n_windows += expected.all_unknown;
				kept_windows += expected.window_kept;
			end
		end
	end

	initial begin
		#10_000_000;
		$display("gc_window_depth_stats_test failed");
		$finish;
	end

	initial begin
		int w;
		int n_pct;
		cfg_width = WINDOW_WIDTH_RESET;
		cfg_min_valid = MIN_VALID_RESET;
		clear_window();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset setting: a partial window left open
		queue_bases(40, 10, 0, 10);
		settle();

		// narrower width closes the open partial window on the next base
		configure(16'd3, 16'd0);
		push_base(BASE_A_UPPER, 16'd5, 1'b0);
		push_base(ASCII_G_UPPER, DEPTH_MAX, 1'b1);
		push_base(ASCII_C_UPPER, 16'd0, 1'b0);
		push_base(ASCII_G_LOWER, 16'd1, 1'b0);
		push_base(ASCII_N_UPPER, 16'd7, 1'b0);
		push_base(ASCII_N_LOWER, 16'd9, 1'b0);
		push_base(ASCII_N_UPPER, DEPTH_MAX, 1'b0);
		push_base(8'h00, 16'd0, 1'b0);
		push_base(8'hFF, DEPTH_MAX, 1'b0);
		push_base(ASCII_C_LOWER, 16'd3, 1'b0);
		push_base(ASCII_G_UPPER, 16'd100, 1'b0);
		push_base(ASCII_C_UPPER, 16'd200, 1'b0);
		push_base(BASE_A_UPPER, 16'd300, 1'b1);
		push_base(BASE_T_UPPER, 16'd4, 1'b0);
		push_base(ASCII_N_UPPER, 16'd5, 1'b0);
		settle();

		// N fraction right at three quarters, then at one half
		configure(16'd4, 16'd0);
		push_base(ASCII_N_UPPER, 16'd1, 1'b1);
		push_base(ASCII_N_LOWER, 16'd2, 1'b0);
		push_base(ASCII_N_UPPER, 16'd3, 1'b0);
		push_base(ASCII_G_UPPER, 16'd4, 1'b0);
		push_base(ASCII_N_UPPER, 16'd5, 1'b0);
		push_base(ASCII_N_LOWER, 16'd6, 1'b0);
		push_base(BASE_A_LOWER, 16'd7, 1'b0);
		push_base(ASCII_G_LOWER, 16'd8, 1'b0);
		settle();

		// zero width acts as one base per window
		configure(16'd0, 16'd0);
		push_base(ASCII_N_UPPER, 16'd1, 1'b1);
		push_base(ASCII_G_UPPER, DEPTH_MAX, 1'b0);
		push_base(BASE_T_LOWER, 16'd0, 1'b1);
		settle();

		// every window rejected by the valid-base minimum
		configure(16'd7, 16'd65535);
		queue_bases(100, 20, 2, 10);
		settle();

		configure(16'd1, 16'd0);
		queue_bases(100, 50, 5, 10);
		settle();

		configure(16'd2, 16'd1);
		queue_bases(100, 60, 5, 10);
		settle();

		for (int p = 0; p < 6; p++) begin
			w = $urandom_range(1, 48);
			case ($urandom_range(2))
				0: n_pct = 5;
				1: n_pct = 35;
				default: n_pct = 80;
			endcase
			configure(16'(w), 16'($urandom_range(w)));
			queue_bases(100, n_pct, 3, 10);
			settle();
		end

		// widest window with deep bases, then closed by lowering the width
		configure(16'd65535, 16'd0);
		push_base(pick_base(25), DEPTH_MAX, 1'b1);
		queue_bases(99, 25, 0, 70);
		settle();
		configure(16'd50, 16'd10);
		push_base(ASCII_G_UPPER, DEPTH_MAX, 1'b0);
		settle();

		$display("Checked %0d windows (%0d all-N, %0d kept) from %0d bases",
			windows_checked, all_n_windows, kept_windows, bases_queued);
		$display("over %0d register settings, widths 0 to 65535", settings_used);
		if (errors == 0 && win_stats_due.size() == 0)
			$display("gc_window_depth_stats_test passed");
		else
			$display("gc_window_depth_stats_test failed");
		$finish;
	end

endmodule

FILE: sim.f
hdl/gcwds_pkg.sv
hdl/gc_window_depth_stats.sv
verif/gc_window_depth_stats_test.sv
